@@ sv/tdf_pkg.sv @@
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared constants and types for the trial division factorizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

  // default width of the value to factor
  localparam int VALUE_BITS_DEF = 31;

  // result field widths
  localparam int PRIME_W = 31;
  localparam int EXP_W   = 5;

  // at most this many results per input value
  localparam int MAX_RESULTS = 9;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // first trial divisor
  localparam int FIRST_DIVISOR = 2;

  // queue depths
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  // input classes decided by the front part
  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_NUM  = 2'd2
  } cls_t;

  // one result item
  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic [EXP_W-1:0]   exponent;
    logic               undefined;
    logic               empty_res;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

@@ sv/trial_division_factorizer_top.sv @@
// ----------------------------------------------------------------------------
// trial_division_factorizer_top
// Factors a non-negative integer by trial division, giving each prime with
// its exponent in increasing order.
//
//   channel | ports                                       | handshake
//   --------+---------------------------------------------+-----------------
//   input   | in_value                                    | in_push / in_full
//   result  | out_prime out_exponent out_undefined        | out_pop / out_empty
//           | out_empty_res out_last                      |
//
// Each trial division runs in the serial divider, after a bound check of each
// candidate; candidates are 2 and then odd numbers while candidate squared
// stays within the unfactored part. A prime near 2^31 takes about 23,200
// candidates. Reset is synchronous and needs no sweep. Up to two values queue
// ahead of the engine; a full result queue stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_factorizer_top #(
  parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  input  wire logic [VALUE_BITS-1:0]         in_value,
  output logic                               in_full,
  input  wire logic                          out_pop,
  output logic                               out_empty,
  output logic [tdf_pkg::PRIME_W-1:0]        out_prime,
  output logic [tdf_pkg::EXP_W-1:0]          out_exponent,
  output logic                               out_undefined,
  output logic                               out_empty_res,
  output logic                               out_last
);

  logic                  cmd_empty;
  logic                  cmd_pop;
  tdf_pkg::cls_t         cmd_cls;
  logic [VALUE_BITS-1:0] cmd_value;
  logic                  res_full;
  logic                  res_push;
  tdf_pkg::res_t         res_din;
  tdf_pkg::res_t         res_dout;

  // front: accept and classify
  tdf_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_value  (in_value),
    .in_full   (in_full),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd_cls   (cmd_cls),
    .cmd_value (cmd_value)
  );

  // back: factoring engine
  tdf_engine #(
    .VALUE_BITS (VALUE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_cls   (cmd_cls),
    .cmd_value (cmd_value),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_din)
  );

  // result queue
  tdf_fifo #(
    .WIDTH ($bits(tdf_pkg::res_t)),
    .DEPTH (tdf_pkg::RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_din),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_dout),
    .empty (out_empty)
  );

  assign out_prime     = res_dout.prime;
  assign out_exponent  = res_dout.exponent;
  assign out_undefined = res_dout.undefined;
  assign out_empty_res = res_dout.empty_res;
  assign out_last      = res_dout.last;

endmodule

`default_nettype wire

@@ sv/tdf_fifo.sv @@
// ----------------------------------------------------------------------------
// tdf_fifo
// Small register-based first-in first-out queue with push/full, pop/empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             wr_en;
  logic             rd_en;

  // status and read data
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

@@ sv/tdf_front.sv @@
// ----------------------------------------------------------------------------
// tdf_front
// Takes input transfers, sorts each value into zero, one or ordinary, and
// queues it for the factoring engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_front #(
  parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       in_full,
  input  wire logic                  cmd_pop,
  output logic                       cmd_empty,
  output tdf_pkg::cls_t              cmd_cls,
  output logic      [VALUE_BITS-1:0] cmd_value
);

  localparam int CMD_W = VALUE_BITS + 2;

  tdf_pkg::cls_t    cls;
  logic [CMD_W-1:0] cmd_din;
  logic [CMD_W-1:0] cmd_dout;

  // classify the incoming value
  always_comb begin
    if (in_value == '0) begin
      cls = tdf_pkg::CLS_ZERO;
    end else if (in_value == VALUE_BITS'(1)) begin
      cls = tdf_pkg::CLS_ONE;
    end else begin
      cls = tdf_pkg::CLS_NUM;
    end
  end

  assign cmd_din = {cls, in_value};

  // command queue between front and back
  tdf_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (tdf_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cmd_din),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty)
  );

  assign cmd_cls   = tdf_pkg::cls_t'(cmd_dout[CMD_W-1 -: 2]);
  assign cmd_value = cmd_dout[VALUE_BITS-1:0];

endmodule

`default_nettype wire

@@ sv/tdf_div.sv @@
// ----------------------------------------------------------------------------
// tdf_div
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_div #(
  parameter int W = tdf_pkg::VALUE_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic      [W-1:0] quot,
  output logic      [W-1:0] rem
);

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     dsr_r, dsr_nxt;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             fits;

  // one shift-subtract step
  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[W-2:0], fits};
      rem_nxt = fits ? diff[W-1:0] : trial[W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

@@ sv/tdf_engine.sv @@
// ----------------------------------------------------------------------------
// tdf_engine
// Back part: runs trial division on one queued value at a time and pushes
// prime/exponent results, holding one back so the final one can carry last.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_engine #(
  parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cmd_empty,
  input  wire tdf_pkg::cls_t         cmd_cls,
  input  wire logic [VALUE_BITS-1:0] cmd_value,
  output logic                       cmd_pop,
  input  wire logic                  res_full,
  output logic                       res_push,
  output tdf_pkg::res_t              res_data
);

  localparam int W = VALUE_BITS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SPEC  = 6'b000010,
    S_CHECK = 6'b000100,
    S_DIV   = 6'b001000,
    S_REC   = 6'b010000,
    S_TAIL  = 6'b100000
  } eng_state_t;

  eng_state_t                       state_r, state_nxt;
  tdf_pkg::cls_t                    cls_r, cls_nxt;
  logic [W-1:0]                     n_r, n_nxt;
  logic [W-1:0]                     d_r, d_nxt;
  logic [W:0]                       sq_r, sq_nxt;
  logic [tdf_pkg::EXP_W-1:0]        e_r, e_nxt;
  logic                             hit_r, hit_nxt;
  logic [tdf_pkg::RES_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                             pend_v_r, pend_v_nxt;
  logic [tdf_pkg::PRIME_W-1:0]      pend_p_r, pend_p_nxt;
  logic [tdf_pkg::EXP_W-1:0]        pend_e_r, pend_e_nxt;

  logic         div_start;
  logic [W-1:0] div_dividend;
  logic         div_done;
  logic [W-1:0] div_quot;
  logic [W-1:0] div_rem;

  logic         room_left;
  logic         have_left;
  logic [W-1:0] d_adv;
  logic [W:0]   sq_adv;

  // single serial divider, reused for every candidate
  tdf_div #(
    .W (W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (d_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // next candidate: 2 goes to 3, then odd steps; square kept by adding
  always_comb begin
    if (d_r == W'(tdf_pkg::FIRST_DIVISOR)) begin
      d_adv  = W'(3);
      sq_adv = (W + 1)'(9);
    end else begin
      d_adv  = d_r + W'(2);
      sq_adv = sq_r + {d_r, 1'b0} + {d_r, 1'b0} + (W + 1)'(4);
    end
  end

  assign room_left = (cnt_r < tdf_pkg::RES_CNT_W'(tdf_pkg::MAX_RESULTS));
  assign have_left = (n_r > W'(1)) && room_left;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cls_nxt      = cls_r;
    n_nxt        = n_r;
    d_nxt        = d_r;
    sq_nxt       = sq_r;
    e_nxt        = e_r;
    hit_nxt      = hit_r;
    cnt_nxt      = cnt_r;
    pend_v_nxt   = pend_v_r;
    pend_p_nxt   = pend_p_r;
    pend_e_nxt   = pend_e_r;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res_data     = '0;
    div_start    = 1'b0;
    div_dividend = n_r;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          cls_nxt    = cmd_cls;
          n_nxt      = cmd_value;
          d_nxt      = W'(tdf_pkg::FIRST_DIVISOR);
          sq_nxt     = (W + 1)'(tdf_pkg::FIRST_DIVISOR * tdf_pkg::FIRST_DIVISOR);
          e_nxt      = '0;
          hit_nxt    = 1'b0;
          cnt_nxt    = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = (cmd_cls == tdf_pkg::CLS_NUM) ? S_CHECK : S_SPEC;
        end
      end
      // zero or one: a single flagged result
      S_SPEC: begin
        if (!res_full) begin
          res_push           = 1'b1;
          res_data.undefined = (cls_r == tdf_pkg::CLS_ZERO);
          res_data.empty_res = (cls_r == tdf_pkg::CLS_ONE);
          res_data.last      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      // loop bound: divisor squared against what is left, and room for results
      S_CHECK: begin
        if ((sq_r <= {1'b0, n_r}) && room_left) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_TAIL;
        end
      end
      // divide out the candidate as often as it goes
      S_DIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            n_nxt        = div_quot;
            e_nxt        = e_r + 1'b1;
            hit_nxt      = 1'b1;
            div_start    = 1'b1;
            div_dividend = div_quot;
          end else if (hit_r) begin
            state_nxt = S_REC;
          end else begin
            d_nxt     = d_adv;
            sq_nxt    = sq_adv;
            state_nxt = S_CHECK;
          end
        end
      end
      // record a found factor, releasing the one held before it
      S_REC: begin
        if (!pend_v_r || !res_full) begin
          if (pend_v_r) begin
            res_push          = 1'b1;
            res_data.prime    = pend_p_r;
            res_data.exponent = pend_e_r;
          end
          pend_v_nxt = 1'b1;
          pend_p_nxt = tdf_pkg::PRIME_W'(d_r);
          pend_e_nxt = e_r;
          cnt_nxt    = cnt_r + 1'b1;
          e_nxt      = '0;
          hit_nxt    = 1'b0;
          d_nxt      = d_adv;
          sq_nxt     = sq_adv;
          state_nxt  = S_CHECK;
        end
      end
      // held factor, then the leftover prime if any
      S_TAIL: begin
        if (pend_v_r) begin
          if (!res_full) begin
            res_push          = 1'b1;
            res_data.prime    = pend_p_r;
            res_data.exponent = pend_e_r;
            res_data.last     = !have_left;
            pend_v_nxt        = 1'b0;
            if (!have_left) begin
              state_nxt = S_IDLE;
            end
          end
        end else if (!have_left) begin
          state_nxt = S_IDLE;
        end else if (!res_full) begin
          res_push          = 1'b1;
          res_data.prime    = tdf_pkg::PRIME_W'(n_r);
          res_data.exponent = tdf_pkg::EXP_W'(1);
          res_data.last     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  // working values, no reset needed
  always_ff @(posedge clk) begin
    cls_r    <= cls_nxt;
    n_r      <= n_nxt;
    d_r      <= d_nxt;
    sq_r     <= sq_nxt;
    e_r      <= e_nxt;
    hit_r    <= hit_nxt;
    cnt_r    <= cnt_nxt;
    pend_p_r <= pend_p_nxt;
    pend_e_r <= pend_e_nxt;
  end

endmodule

`default_nettype wire

@@ sv/tdf_checker.sv @@
// ----------------------------------------------------------------------------
// tdf_checker
// Port-level checks on the factorizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_push,
  input wire logic                          in_full,
  input wire logic                          out_pop,
  input wire logic                          out_empty,
  input wire logic [tdf_pkg::PRIME_W-1:0]   out_prime,
  input wire logic [tdf_pkg::EXP_W-1:0]     out_exponent,
  input wire logic                          out_undefined,
  input wire logic                          out_empty_res,
  input wire logic                          out_last
);

  // nothing waits and input is open right after reset
  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (out_empty && !in_full))
    else $error("queues not clear after reset");

  // input only fills up after an offered transfer
  a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("input full without a transfer");

  // an undefined result stands alone with zero fields
  a_undef_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_undefined) |->
      (out_last && !out_empty_res && out_prime == '0 && out_exponent == '0))
    else $error("malformed undefined result");

  // an empty result stands alone with zero fields
  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_empty_res) |->
      (out_last && !out_undefined && out_prime == '0 && out_exponent == '0))
    else $error("malformed empty result");

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_prime) && $stable(out_exponent) && $stable(out_last)))
    else $error("result changed while waiting");

endmodule

bind trial_division_factorizer_top tdf_checker u_tdf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_push       (in_push),
  .in_full       (in_full),
  .out_pop       (out_pop),
  .out_empty     (out_empty),
  .out_prime     (out_prime),
  .out_exponent  (out_exponent),
  .out_undefined (out_undefined),
  .out_empty_res (out_empty_res),
  .out_last      (out_last)
);

`default_nettype wire

@@ tb/trial_division_factorizer_top_test.sv @@
// ----------------------------------------------------------------------------
// trial_division_factorizer_top_test
// Self-checking bench for the trial division factorizer. Values go in through
// the push/full queue; each popped prime/exponent result is compared against
// a local factorization of the same value, in order. Covers zero, one, primes,
// high powers, nine distinct factors, the full input range, result stalls
// and input backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_factorizer_top_test;

  localparam int VBITS = tdf_pkg::VALUE_BITS_DEF;
  localparam longint unsigned VALUE_MAX = (64'd1 << VBITS) - 1;
  localparam int unsigned LIMIT_CYCLES = 6_000_000;
  localparam int STALL_CYCLES = 600;
  localparam int IDLE_PCT = 18;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic [VBITS-1:0] in_value = '0;
  logic             in_full;
  logic             out_pop = 1'b0;
  logic             out_empty;
  logic [tdf_pkg::PRIME_W-1:0] out_prime;
  logic [tdf_pkg::EXP_W-1:0] out_exponent;
  logic             out_undefined;
  logic             out_empty_res;
  logic             out_last;

  // factor results still owed by the block, oldest first
  tdf_pkg::res_t pending_factors[$];

  int          error_count = 0;
  int          values_sent = 0;
  int          results_checked = 0;
  int          full_cycles = 0;
  int unsigned cycle_count = 0;
  bit          send_idle_on = 1'b1;
  bit          pop_idle_on = 1'b1;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;
  bit          stalled = 1'b0;

  trial_division_factorizer_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_value     (in_value),
    .in_full      (in_full),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_prime    (out_prime),
    .out_exponent (out_exponent),
    .out_undefined(out_undefined),
    .out_empty_res(out_empty_res),
    .out_last     (out_last)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // cycle count, backpressure count and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_push && in_full) full_cycles <= full_cycles + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_factors.size());
      $display("simulation failed");
      $finish;
    end
  end

  // factor one value by trial division and queue the results it owes
  function automatic void factorize_into_pending(input logic [VBITS-1:0] v);
    longint unsigned rest;
    longint unsigned d;
    int              e;
    tdf_pkg::res_t   r;
    tdf_pkg::res_t   found[$];
    rest = v;
    r = '0;
    if (rest == 0) begin
      r.undefined = 1'b1;
      found.push_back(r);
    end else if (rest == 1) begin
      r.empty_res = 1'b1;
      found.push_back(r);
    end else begin
      for (d = 2; d * d <= rest && found.size() < tdf_pkg::MAX_RESULTS; d++) begin
        e = 0;
        while (rest % d == 0) begin
          rest = rest / d;
          e++;
        end
        if (e != 0) begin
          r = '0;
          r.prime = d[tdf_pkg::PRIME_W-1:0];
          r.exponent = e[tdf_pkg::EXP_W-1:0];
          found.push_back(r);
        end
      end
      // leftover part is itself prime
      if (rest > 1 && found.size() < tdf_pkg::MAX_RESULTS) begin
        r = '0;
        r.prime = rest[tdf_pkg::PRIME_W-1:0];
        r.exponent = tdf_pkg::EXP_W'(1);
        found.push_back(r);
      end
    end
    found[found.size() - 1].last = 1'b1;
    foreach (found[i]) pending_factors.push_back(found[i]);
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 40) $display("ERROR @%0t: %s", $time, what);
  endtask

  // compare one popped result with the oldest pending one
  task automatic check_factor_result();
    tdf_pkg::res_t want;
    if (pending_factors.size() == 0) begin
      report_mismatch($sformatf("unexpected result prime %0d exponent %0d",
                                out_prime, out_exponent));
      return;
    end
    want = pending_factors.pop_front();
    results_checked++;
    if (out_prime !== want.prime)
      report_mismatch($sformatf("prime %0d, want %0d", out_prime, want.prime));
    if (out_exponent !== want.exponent)
      report_mismatch($sformatf("exponent %0d, want %0d (prime %0d)",
                                out_exponent, want.exponent, want.prime));
    if (out_undefined !== want.undefined)
      report_mismatch($sformatf("undefined %b, want %b", out_undefined,
                                want.undefined));
    if (out_empty_res !== want.empty_res)
      report_mismatch($sformatf("empty_res %b, want %b", out_empty_res,
                                want.empty_res));
    if (out_last !== want.last)
      report_mismatch($sformatf("last %b, want %b (prime %0d)", out_last,
                                want.last, want.prime));
  endtask

  // result side: check each transfer, then pick the next pop
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) check_factor_result();
      if (stalled) out_pop <= 1'b0;
      else if (pop_idle_on) out_pop <= ($urandom_range(99) >= IDLE_PCT);
      else out_pop <= 1'b1;
    end
  end

  // long result stall, counted here once requested
  initial begin
    wait (hold_request);
    stalled <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    stalled <= 1'b0;
    hold_done = 1'b1;
  end

  // offer one value and wait for its transfer
  task automatic send_value(input logic [VBITS-1:0] v);
    int gap;
    if (send_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_push <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_full) @(posedge clk);
    factorize_into_pending(v);
    values_sent++;
  endtask

  // stop offering and wait until every owed result has been popped
  task automatic stop_and_drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_factors.size() != 0) @(posedge clk);
  endtask

  // multiply base by small random factors while it still fits
  function automatic logic [VBITS-1:0] grow_value(input longint unsigned base,
                                                  input int terms);
    longint unsigned acc;
    longint unsigned f;
    int              i;
    acc = base;
    for (i = 0; i < terms; i++) begin
      f = $urandom_range(2, 97);
      if (acc * f <= VALUE_MAX) acc = acc * f;
    end
    return acc[VBITS-1:0];
  endfunction

  // mostly small or smooth values so that trial division stays short
  function automatic logic [VBITS-1:0] random_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 4) return '0;
    if (sel < 8) return VBITS'(1);
    if (sel < 40) return VBITS'($urandom_range(2, 4095));
    if (sel < 80) return grow_value(1, $urandom_range(1, 14));
    return grow_value($urandom_range(2, 65535), $urandom_range(0, 8));
  endfunction

  // zero, one, small primes, high powers, leftover prime, nine factors, range ends
  task automatic test_directed_values();
    send_value(0);
    send_value(1);
    send_value(2);
    send_value(3);
    send_value(4);
    send_value(49);
    send_value(97);
    send_value(65535);
    send_value(262084);
    send_value(30030);
    send_value(746496);
    send_value(223092870);
    send_value(1162261467);
    send_value(1073741824);
    send_value(1610612736);
    send_value(2147483646);
    send_value(2147483647);
    stop_and_drain();
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    int i;
    send_idle_on = 1'b0;
    pop_idle_on <= 1'b0;
    for (i = 0; i < 30; i++) send_value(random_value());
    stop_and_drain();
    send_idle_on = 1'b1;
    pop_idle_on <= 1'b1;
  endtask

  // results held back while many-factor values keep coming
  task automatic test_result_stall();
    int i;
    send_idle_on = 1'b0;
    hold_request = 1'b1;
    @(posedge clk);
    for (i = 0; i < 10; i++) send_value(VBITS'(30030 * $urandom_range(1, 40)));
    wait (hold_done);
    stop_and_drain();
    send_idle_on = 1'b1;
  endtask

  // burst, full drain, then a second burst into an idle block
  task automatic test_pause_refill();
    int i;
    for (i = 0; i < 6; i++) send_value(random_value());
    stop_and_drain();
    for (i = 0; i < 6; i++) send_value(random_value());
    stop_and_drain();
  endtask

  task automatic test_random_values();
    int i;
    for (i = 0; i < 50; i++) send_value(random_value());
    stop_and_drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_values();
    test_back_to_back();
    test_result_stall();
    test_pause_refill();
    test_random_values();
    // catch any stray result after the last one owed
    repeat (50) @(posedge clk);
    $display("factored %0d values, %0d results checked in order, %0d mismatches",
             values_sent, results_checked, error_count);
    $display("input backpressure held %0d cycles, run took %0d cycles",
             full_cycles, cycle_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/tdf_pkg.sv
sv/tdf_fifo.sv
sv/tdf_front.sv
sv/tdf_div.sv
sv/tdf_engine.sv
sv/trial_division_factorizer_top.sv
sv/tdf_checker.sv
tb/trial_division_factorizer_top_test.sv
